// ===== hdl/ehm_pkg.sv =====
`default_nettype none

package ehm_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MIN_SAMPLE   = 3'd0,
    CFG_MIN_DISTINCT = 3'd1,
    CFG_REP_NUM      = 3'd2,
    CFG_REP_DEN      = 3'd3,
    CFG_MIN_PCT      = 3'd4,
    CFG_MAX_PCT      = 3'd5
  } ehm_cfg_idx_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // reset values of the thresholds
  localparam logic [31:0] MIN_SAMPLE_RST   = 32'd256;
  localparam logic [8:0]  MIN_DISTINCT_RST = 9'd128;
  localparam logic [15:0] REP_NUM_RST      = 16'd1;
  localparam logic [15:0] REP_DEN_RST      = 16'd8;
  localparam logic [6:0]  MIN_PCT_RST      = 7'd45;
  localparam logic [6:0]  MAX_PCT_RST      = 7'd55;

  localparam logic [29:0] WORD_MAX       = 30'h3FFF_FFFF;
  localparam logic [6:0]  PERCENT_SCALE  = 7'd100;
  localparam logic [1:0]  LAST_FILL      = 2'd3;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 104;

  // live threshold set
  typedef struct packed {
    logic [31:0] min_sample;
    logic [8:0]  min_distinct;
    logic [15:0] rep_num;
    logic [15:0] rep_den;
    logic [6:0]  min_pct;
    logic [6:0]  max_pct;
  } ehm_cfg_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] value;
    logic [3:0] ones;
    logic       new_value;
  } ehm_item_t;

endpackage

`default_nettype wire

// ===== hdl/ehm_front.sv =====
`default_nettype none

module ehm_front
  import ehm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,  // [7:0] sample_byte
  input  wire logic                 q_full,
  output logic                      q_push,
  output ehm_item_t                 q_item
);

  logic [255:0] seen_r;
  logic [255:0] seen_nxt;
  logic [7:0]   value;
  logic [3:0]   ones;

  assign value     = in_tdata[7:0];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  // popcount of the sample byte
  always_comb begin
    ones = 4'd0;
    for (int i = 0; i < 8; i++) begin
      ones = ones + {3'd0, value[i]};
    end
  end

  assign q_item.value     = value;
  assign q_item.ones      = ones;
  assign q_item.new_value = !seen_r[value];

  // seen map marks each value on its first transfer
  always_comb begin
    seen_nxt = seen_r;
    if (q_push) begin
      seen_nxt[value] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ehm_queue.sv =====
`default_nettype none

module ehm_queue
  import ehm_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire ehm_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output ehm_item_t      head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ehm_item_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ehm_back.sv =====
`default_nettype none

module ehm_back
  import ehm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ehm_cfg_t              cfg,
  input  wire logic                  item_valid,
  input  wire ehm_item_t             item,
  output logic                       pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] healthy, [32:1] byte_count, [41:33] distinct_count, [71:42] word_count,
  // [101:72] repeat_count, [102] all_constant, [103] zero
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic advance;

  // running statistics
  logic [31:0] byte_total_r, byte_total_nxt;
  logic [34:0] ones_total_r, ones_total_nxt;
  logic [8:0]  distinct_r, distinct_nxt;
  logic [23:0] partial_r, partial_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [29:0] word_total_r, word_total_nxt;
  logic [31:0] or_r, or_nxt;
  logic [31:0] and_r, and_nxt;
  logic [29:0] repeat_r, repeat_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [31:0] first_r, first_nxt;
  logic        word_seen_r, word_seen_nxt;
  logic        const_r, const_nxt;
  logic [31:0] word;

  // pipeline valid bits
  logic s1_valid_r, s1_valid_nxt;
  logic s2_valid_r, s2_valid_nxt;
  logic out_valid_r, out_valid_nxt;

  // product stage
  logic [45:0] rep_lhs_r, rep_rhs_r;
  logic [41:0] ones_pct_r;
  logic [38:0] low_pct_r, high_pct_r;
  logic        base_ok_r;
  logic [31:0] s2_bytes_r;
  logic [8:0]  s2_distinct_r;
  logic [29:0] s2_words_r, s2_repeats_r;
  logic        s2_const_r;

  // output register
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  healthy;

  assign advance    = !out_valid_r || out_tready;
  assign pop        = advance && item_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign word       = {partial_r, item.value};

  // statistics update, one byte per transfer out of the queue
  always_comb begin
    byte_total_nxt = byte_total_r;
    ones_total_nxt = ones_total_r;
    distinct_nxt   = distinct_r;
    partial_nxt    = partial_r;
    fill_nxt       = fill_r;
    word_total_nxt = word_total_r;
    or_nxt         = or_r;
    and_nxt        = and_r;
    repeat_nxt     = repeat_r;
    prev_nxt       = prev_r;
    first_nxt      = first_r;
    word_seen_nxt  = word_seen_r;
    const_nxt      = const_r;
    if (pop) begin
      // byte and ones counts freeze together once the byte count is full
      if (!(&byte_total_r)) begin
        byte_total_nxt = byte_total_r + 32'd1;
        ones_total_nxt = ones_total_r + {31'd0, item.ones};
      end
      if (item.new_value) begin
        distinct_nxt = distinct_r + 9'd1;
      end
      if (fill_r != LAST_FILL) begin
        partial_nxt = {partial_r[15:0], item.value};
        fill_nxt    = fill_r + 2'd1;
      end else begin
        partial_nxt = '0;
        fill_nxt    = '0;
        if (word_total_r != WORD_MAX) begin
          word_total_nxt = word_total_r + 30'd1;
        end
        or_nxt  = or_r | word;
        and_nxt = and_r & word;
        if (word_seen_r && (word == prev_r) && (repeat_r != WORD_MAX)) begin
          repeat_nxt = repeat_r + 30'd1;
        end
        prev_nxt = word;
        if (!word_seen_r) begin
          word_seen_nxt = 1'b1;
          first_nxt     = word;
          const_nxt     = 1'b1;
        end else if (word != first_r) begin
          const_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_total_r <= '0;
      ones_total_r <= '0;
      distinct_r   <= '0;
      partial_r    <= '0;
      fill_r       <= '0;
      word_total_r <= '0;
      or_r         <= '0;
      and_r        <= '1;
      repeat_r     <= '0;
      prev_r       <= '0;
      first_r      <= '0;
      word_seen_r  <= 1'b0;
      const_r      <= 1'b0;
    end else begin
      byte_total_r <= byte_total_nxt;
      ones_total_r <= ones_total_nxt;
      distinct_r   <= distinct_nxt;
      partial_r    <= partial_nxt;
      fill_r       <= fill_nxt;
      word_total_r <= word_total_nxt;
      or_r         <= or_nxt;
      and_r        <= and_nxt;
      repeat_r     <= repeat_nxt;
      prev_r       <= prev_nxt;
      first_r      <= first_nxt;
      word_seen_r  <= word_seen_nxt;
      const_r      <= const_nxt;
    end
  end

  // valid bits move together while the output side is not stalled
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s2_valid_nxt  = s2_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      s1_valid_nxt  = pop;
      s2_valid_nxt  = s1_valid_r;
      out_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // products for the ratio tests plus the simple threshold checks
  always_ff @(posedge clk) begin
    if (advance) begin
      rep_lhs_r     <= 46'(repeat_r) * 46'(cfg.rep_den);
      rep_rhs_r     <= 46'(word_total_r) * 46'(cfg.rep_num);
      ones_pct_r    <= 42'(ones_total_r) * 42'(PERCENT_SCALE);
      low_pct_r     <= 39'(byte_total_r) * 39'(cfg.min_pct);
      high_pct_r    <= 39'(byte_total_r) * 39'(cfg.max_pct);
      base_ok_r     <= (byte_total_r >= cfg.min_sample) && (word_total_r != '0) &&
                       (or_r != '0) && !(&and_r) && !const_r &&
                       (distinct_r >= cfg.min_distinct);
      s2_bytes_r    <= byte_total_r;
      s2_distinct_r <= distinct_r;
      s2_words_r    <= word_total_r;
      s2_repeats_r  <= repeat_r;
      s2_const_r    <= const_r;
    end
  end

  // final verdict; bit totals are byte totals times eight
  assign healthy = base_ok_r && (rep_lhs_r <= rep_rhs_r) &&
                   (ones_pct_r >= {low_pct_r, 3'b000}) &&
                   (ones_pct_r <= {high_pct_r, 3'b000});

  assign out_data_nxt = {1'b0, s2_const_r, s2_repeats_r, s2_words_r,
                         s2_distinct_r, s2_bytes_r, healthy};

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/entropy_health_monitor_unit.sv =====
// each byte passes the queue, statistics registers, product stage and output register
// throughput: one byte per cycle unless the output is held, set by the statistics update
// a 4-entry queue (QUEUE_DEPTH) takes bytes while the output is held, until it is full
// reset (rst_n, synchronous): counters, word tracking and the 256-entry seen map clear;
// thresholds return to 256, 128, 1/8, 45 and 55 percent
`default_nettype none

module entropy_health_monitor_unit
  import ehm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input stream
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [IN_DATA_W-1:0]    in_tdata,   // [7:0] sample_byte
  // result stream
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // [0] healthy, [32:1] byte_count, [41:33] distinct_count, [71:42] word_count,
  // [101:72] repeat_count, [102] all_constant, [103] zero
  output logic [OUT_DATA_W-1:0]        out_tdata,
  // configuration writes
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata
);

  ehm_cfg_t  cfg_r, cfg_nxt;
  ehm_item_t push_item, head_item;
  logic      q_push, q_full, q_pop, q_not_empty;

  // threshold register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (ehm_cfg_idx_t'(cfg_index))
        CFG_MIN_SAMPLE:   cfg_nxt.min_sample   = cfg_wdata;
        CFG_MIN_DISTINCT: cfg_nxt.min_distinct = cfg_wdata[8:0];
        CFG_REP_NUM:      cfg_nxt.rep_num      = cfg_wdata[15:0];
        CFG_REP_DEN:      cfg_nxt.rep_den      = cfg_wdata[15:0];
        CFG_MIN_PCT:      cfg_nxt.min_pct      = cfg_wdata[6:0];
        CFG_MAX_PCT:      cfg_nxt.max_pct      = cfg_wdata[6:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_sample   <= MIN_SAMPLE_RST;
      cfg_r.min_distinct <= MIN_DISTINCT_RST;
      cfg_r.rep_num      <= REP_NUM_RST;
      cfg_r.rep_den      <= REP_DEN_RST;
      cfg_r.min_pct      <= MIN_PCT_RST;
      cfg_r.max_pct      <= MAX_PCT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classify incoming bytes
  ehm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // decoupling queue
  ehm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  // statistics and verdict
  ehm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_not_empty),
    .item       (head_item),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
